[rtl/greedy_iou_nms_top_assert.svh]
// ----------------------------------------------------------------------------
// Greedy IoU NMS assertion macros
// Concurrent check wrappers sampled on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef GREEDY_IOU_NMS_TOP_ASSERT_SVH
`define GREEDY_IOU_NMS_TOP_ASSERT_SVH

// Condition must hold at every clock edge outside reset
`define GNMS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define GNMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/gnms_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Greedy IoU NMS package
// Sizes, reset values and the kept-list entry layout.
// ----------------------------------------------------------------------------
package gnms_pkg;

  // Kept-list depth and the widths that follow from it
  localparam int unsigned MAX_KEPT = 64;
  localparam int unsigned CNT_W    = $clog2(MAX_KEPT + 1);
  localparam int unsigned ADDR_W   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

  // Fixed field widths
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned AREA_W   = 32;
  localparam int unsigned THR_W    = 16;
  localparam int unsigned IDX_W    = 16;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned UNI_W    = AREA_W + 1;
  localparam int unsigned PROD_W   = UNI_W + THR_W;
  localparam int unsigned LHS_W    = AREA_W + 16;

  localparam logic [THR_W-1:0] THR_RESET = 16'd29491;
  localparam logic [IDX_W-1:0] IDX_MAX   = 16'hFFFF;

  // One kept-list entry: box and its precomputed area
  typedef struct packed {
    logic [AREA_W-1:0]         area;
    logic [COORD_W-1:0]        h;
    logic [COORD_W-1:0]        w;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } kept_entry_t;

endpackage
`default_nettype wire

[rtl/greedy_iou_nms_top.sv]
// Flow: each box is compared against N kept boxes (N up to 64); the input stalls
//   from the accepted beat until its result beat is loaded, so one box at a time.
// The kept-list memory feeds one entry per cycle to a five-stage overlap/compare
//   unit, which fills and drains for each box.
// Reset: kept count, item counter and control clear at once, the threshold
//   returns to 29491; the kept-list memory is not cleared and needs no pass.
`default_nettype none
// ----------------------------------------------------------------------------
// Greedy IoU non-maximum suppression
// Each box is checked against every kept box of the frame through one shared
// pipelined overlap unit; survivors are appended to the kept-list memory while it has room.
// ----------------------------------------------------------------------------
`include "greedy_iou_nms_top_assert.svh"

module greedy_iou_nms_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_we_i,
  input  logic [gnms_pkg::THR_W-1:0]            cfg_wdata_i,
  // input beat
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [gnms_pkg::COORD_W-1:0]   box_x_i,
  input  logic signed [gnms_pkg::COORD_W-1:0]   box_y_i,
  input  logic [gnms_pkg::COORD_W-1:0]          box_width_i,
  input  logic [gnms_pkg::COORD_W-1:0]          box_height_i,
  input  logic                                  first_of_frame_i,
  // result beat
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  keep_o,
  output logic [gnms_pkg::IDX_W-1:0]            item_index_o,
  output logic [gnms_pkg::SLOT_W-1:0]           kept_slot_o,
  output logic                                  overflow_o
);

  import gnms_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_AREA = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [THR_W-1:0]        thr_q;
  logic [CNT_W-1:0]        count_q;
  logic [CNT_W-1:0]        iss_q;
  logic [IDX_W-1:0]        frame_q;
  logic                    keep_q;
  logic                    out_valid_q;

  logic signed [COORD_W-1:0] bx_q, by_q;
  logic [COORD_W-1:0]        bw_q, bh_q;
  logic [AREA_W-1:0]         area_q;
  logic [IDX_W-1:0]          idx_q;

  kept_entry_t             mem_q [MAX_KEPT];
  kept_entry_t             rd_q;
  kept_entry_t             wr_entry;

  // pipeline valids and data
  logic                    rd_v_q, s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic [COORD_W-1:0]      ow_q, oh_q;
  logic [AREA_W-1:0]       ka1_q, ka2_q;
  logic [AREA_W-1:0]       inter2_q, inter3_q;
  logic [UNI_W-1:0]        uni_q;
  logic [LHS_W-1:0]        lhs_q;
  logic [PROD_W-1:0]       prod_q;

  logic                    in_acc, out_acc, out_load;
  logic                    issue, pipe_busy, full, store;
  logic [COORD_W-1:0]      ow_d, oh_d;
  logic [COORD_W-1:0]      mul_a, mul_b;
  logic [AREA_W-1:0]       mul_p;
  logic [UNI_W-1:0]        uni_d;
  logic [PROD_W-1:0]       prod_d;
  logic                    hit;

  // Overlap length of [a0, a0+al) and [b0, b0+bl), zero when disjoint
  function automatic logic [COORD_W-1:0] ovl(
    input logic signed [COORD_W-1:0] a0,
    input logic [COORD_W-1:0]        al,
    input logic signed [COORD_W-1:0] b0,
    input logic [COORD_W-1:0]        bl
  );
    logic signed [COORD_W+1:0] a_s, b_s, a_e, b_e, lo, hi, d;
    a_s = {{2{a0[COORD_W-1]}}, a0};
    b_s = {{2{b0[COORD_W-1]}}, b0};
    a_e = a_s + $signed({2'b00, al});
    b_e = b_s + $signed({2'b00, bl});
    hi  = (a_e < b_e) ? a_e : b_e;
    lo  = (a_s > b_s) ? a_s : b_s;
    d   = hi - lo;
    return (d > 0) ? d[COORD_W-1:0] : '0;
  endfunction

  // Handshake and sequencer conditions
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign issue      = (state_q == ST_RUN) && (iss_q < count_q);
  assign pipe_busy  = rd_v_q || s1_v_q || s2_v_q || s3_v_q || s4_v_q;
  assign full       = (count_q == CNT_W'(MAX_KEPT));
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign store      = out_load && keep_q && !full;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_AREA;
      ST_AREA: state_d = ST_RUN;
      ST_RUN:  if (!issue && !pipe_busy) state_d = ST_DONE;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Shared unit, stage 1: overlap lengths against the kept entry
  assign ow_d = ovl(bx_q, bw_q, rd_q.x, rd_q.w);
  assign oh_d = ovl(by_q, bh_q, rd_q.y, rd_q.h);

  // Shared multiplier: own area once, then one intersection per entry
  assign mul_a = (state_q == ST_AREA) ? bw_q : ow_q;
  assign mul_b = (state_q == ST_AREA) ? bh_q : oh_q;
  assign mul_p = {16'd0, mul_a} * {16'd0, mul_b};

  // Stage 3 union, stage 4 threshold product, stage 5 compare
  assign uni_d  = {1'b0, area_q} + {1'b0, ka2_q} - {1'b0, inter2_q};
  assign prod_d = {{UNI_W{1'b0}}, thr_q} * {{THR_W{1'b0}}, uni_q};
  assign hit    = s4_v_q && ({1'b0, lhs_q} > prod_q);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_q       <= THR_RESET;
      count_q     <= '0;
      iss_q       <= '0;
      frame_q     <= '0;
      keep_q      <= 1'b0;
      out_valid_q <= 1'b0;
      rd_v_q      <= 1'b0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      // take a box: clear the list on a new frame, advance the item counter
      if (in_acc) begin
        iss_q  <= '0;
        keep_q <= 1'b1;
        if (first_of_frame_i) begin
          count_q <= '0;
          frame_q <= IDX_W'(1);
        end else if (frame_q != IDX_MAX) begin
          frame_q <= frame_q + IDX_W'(1);
        end
      end
      if (issue) begin
        iss_q <= iss_q + CNT_W'(1);
      end
      rd_v_q <= issue;
      s1_v_q <= rd_v_q;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      // drop the box on any overlap hit
      if (hit) begin
        keep_q <= 1'b0;
      end
      if (store) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Box registers and pipeline data
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      bx_q  <= box_x_i;
      by_q  <= box_y_i;
      bw_q  <= box_width_i;
      bh_q  <= box_height_i;
      idx_q <= first_of_frame_i ? '0 : frame_q;
    end
    if (state_q == ST_AREA) begin
      area_q <= mul_p;
    end
    ow_q     <= ow_d;
    oh_q     <= oh_d;
    ka1_q    <= rd_q.area;
    inter2_q <= mul_p;
    ka2_q    <= ka1_q;
    uni_q    <= uni_d;
    inter3_q <= inter2_q;
    prod_q   <= prod_d;
    lhs_q    <= {inter3_q, 16'd0};
  end

  // Kept-list memory: append survivors, read one entry per issue
  always_comb begin
    wr_entry.x    = bx_q;
    wr_entry.y    = by_q;
    wr_entry.w    = bw_q;
    wr_entry.h    = bh_q;
    wr_entry.area = area_q;
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      mem_q[count_q[ADDR_W-1:0]] <= wr_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_q <= mem_q[iss_q[ADDR_W-1:0]];
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      keep_o       <= keep_q;
      item_index_o <= idx_q;
      kept_slot_o  <= store ? SLOT_W'(count_q) : '0;
      overflow_o   <= keep_q && full;
    end
  end

  assign out_valid_o = out_valid_q;

  // Checks
  `GNMS_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(MAX_KEPT),
    "kept count beyond list depth")
  `GNMS_ASSERT_ALWAYS(a_issue_bound, iss_q <= count_q,
    "issue pointer beyond kept count")
  `GNMS_ASSERT_IMP(a_drained, state_q == ST_DONE, !pipe_busy,
    "result formed while compares still in flight")
  `GNMS_ASSERT_IMP(a_ovf_keep, out_valid_o && overflow_o,
    keep_o && (kept_slot_o == '0), "overflow beat without keep or with a slot")

endmodule
`default_nettype wire
